### rtl/core/segdf_pkg.sv
// Shared types and constants of the segment table deframer.
package segdf_pkg;

  localparam int WORD_W   = 64;
  localparam int IDX_W    = 9;
  localparam int OFF_W    = 41;
  localparam int SIZE_W   = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_USER_W = 3;
  localparam int OUT_DATA_W = 152;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam int DEFAULT_MAX_SEGMENTS = 512;
  localparam logic [OFF_W-1:0] LIMIT_RESET = 41'd8388608;

  localparam logic REG_LIMIT = 1'b0;
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    RK_DESC    = 3'd0,
    RK_ACCEPT  = 3'd1,
    RK_PAYLOAD = 3'd2,
    RK_ERROR   = 3'd3,
    RK_END     = 3'd4
  } result_kind_t;

  typedef enum logic [1:0] {
    ERR_SEGMENTS  = 2'd0,
    ERR_TOO_LARGE = 2'd1,
    ERR_PREMATURE = 2'd2
  } error_code_t;

  typedef struct packed {
    result_kind_t        kind;
    logic [IDX_W-1:0]    index;
    logic [OFF_W-1:0]    offset;
    logic [SIZE_W-1:0]   size;
    logic [WORD_W-1:0]   payload;
    error_code_t         err;
    logic                last;
  } result_t;

endpackage

### rtl/core/segment_table_deframer.sv
// Segment table deframer: parses message framing tables and forwards payload words.
//
// The in_ channel takes one stream word per item; in_tuser marks an end of stream.
// Each item is parsed in the cycle it is accepted and causes zero to three results,
// which are loaded into a three-entry result register and leave on the out_ channel
// one per cycle while the receiver is ready, result_kind on out_tuser and message_last on out_tlast.
// The first result of an accepted item is presented in the cycle after it is accepted.
// Payload words and single-result items sustain one item per cycle while the receiver is
// ready. A table word that carries two sizes, or ends the table, holds the input until
// the single output channel has drained the result register down to its last result.
// A new item is accepted while the last pending result is being taken.
// When the receiver stalls, results hold and the input stalls while any result is
// pending. Reset returns the parser to idle, empties the result register
// and loads limit_words with its default. After an error the block keeps taking
// items but returns nothing until reset. limit_words sits at cfg_ byte address 0.
module segment_table_deframer #(
  parameter int MAX_SEGMENTS = segdf_pkg::DEFAULT_MAX_SEGMENTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // word
  input  logic [segdf_pkg::WORD_W-1:0]      in_tdata,
  // kind
  input  logic [segdf_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // segment_index, segment_offset, segment_size, payload, error_code, zero fill
  output logic [segdf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // result_kind
  output logic [segdf_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [segdf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [segdf_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [segdf_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import segdf_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TABLE,
    PH_PAYLOAD,
    PH_HALT
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   seg_total_r, seg_total_nxt;
  logic [CNT_W-1:0]   next_index_r, next_index_nxt;
  logic [OFF_W-1:0]   run_offset_r, run_offset_nxt;
  logic [OFF_W-1:0]   words_left_r, words_left_nxt;
  logic               sum_ovf_r, sum_ovf_nxt;
  logic [OFF_W-1:0]   limit_r;
  logic [1:0]         cnt_r;
  result_t            slot_r [3];

  result_t            res [3];
  logic [1:0]         res_cnt;
  logic               in_accept, out_pop, cfg_write;
  logic               in_kind;
  logic [SIZE_W-1:0]  lo, hi;
  logic [OFF_W-1:0]   first_base;
  logic [SIZE_W-1:0]  first_size;
  logic [OFF_W:0]     sum_a_full, sum_b_full;
  logic [OFF_W-1:0]   sum_a, sum_b;
  logic [CNT_W:0]     idx1, idx2;
  logic               do_hi;
  logic [OFF_W-1:0]   fin_total;
  logic               fin_ovf, fin_fail;
  logic [OFF_W-1:0]   words_dec;
  result_t            fin_res;

  assign in_kind = in_tuser[0];
  assign lo = in_tdata[SIZE_W-1:0];
  assign hi = in_tdata[WORD_W-1:SIZE_W];

  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_accept = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_pop = out_tvalid && out_tready;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  assign out_tuser = slot_r[0].kind;
  assign out_tlast = slot_r[0].last;
  assign out_tdata = {4'b0, slot_r[0].err, slot_r[0].payload, slot_r[0].size,
                      slot_r[0].offset, slot_r[0].index};

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_LIMIT) begin
      cfg_prdata = {{(CFG_DATA_W-OFF_W){1'b0}}, limit_r};
    end
  end

  // Saturating running sums for the one or two sizes a word can carry.
  always_comb begin
    first_base = (phase_r == PH_IDLE) ? '0 : run_offset_r;
    first_size = (phase_r == PH_IDLE) ? hi : lo;
    sum_a_full = {1'b0, first_base} + {{(OFF_W+1-SIZE_W){1'b0}}, first_size};
    sum_a = sum_a_full[OFF_W] ? '1 : sum_a_full[OFF_W-1:0];
    sum_b_full = {1'b0, sum_a} + {{(OFF_W+1-SIZE_W){1'b0}}, hi};
    sum_b = sum_b_full[OFF_W] ? '1 : sum_b_full[OFF_W-1:0];
    idx1 = {1'b0, next_index_r} + {{CNT_W{1'b0}}, 1'b1};
    do_hi = (phase_r == PH_TABLE) && (idx1 < {1'b0, seg_total_r});
    idx2 = do_hi ? idx1 + {{CNT_W{1'b0}}, 1'b1} : idx1;
    if (phase_r == PH_IDLE) begin
      fin_total = sum_a;
      fin_ovf = sum_a_full[OFF_W];
    end else begin
      fin_total = do_hi ? sum_b : sum_a;
      fin_ovf = sum_ovf_r || sum_a_full[OFF_W] || (do_hi && sum_b_full[OFF_W]);
    end
    fin_fail = fin_ovf || (fin_total > limit_r);
    fin_res = '0;
    if (fin_fail) begin
      fin_res.kind = RK_ERROR;
      fin_res.err = ERR_TOO_LARGE;
    end else begin
      fin_res.kind = RK_ACCEPT;
      fin_res.offset = fin_total;
      fin_res.last = (fin_total == '0);
    end
    words_dec = words_left_r - {{(OFF_W-1){1'b0}}, 1'b1};
  end

  always_comb begin
    phase_nxt = phase_r;
    seg_total_nxt = seg_total_r;
    next_index_nxt = next_index_r;
    run_offset_nxt = run_offset_r;
    words_left_nxt = words_left_r;
    sum_ovf_nxt = sum_ovf_r;
    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    res_cnt = 2'd0;
    if (phase_r != PH_HALT) begin
      if (in_kind == KIND_END) begin
        res_cnt = 2'd1;
        if (phase_r == PH_IDLE) begin
          res[0].kind = RK_END;
        end else begin
          res[0].kind = RK_ERROR;
          res[0].err = ERR_PREMATURE;
          phase_nxt = PH_HALT;
        end
      end else if (phase_r == PH_PAYLOAD) begin
        res_cnt = 2'd1;
        res[0].kind = RK_PAYLOAD;
        res[0].payload = in_tdata;
        res[0].last = (words_dec == '0);
        words_left_nxt = words_dec;
        if (words_dec == '0) begin
          phase_nxt = PH_IDLE;
        end
      end else if (phase_r == PH_IDLE) begin
        if (&lo) begin
          res_cnt = 2'd1;
          res[0].kind = RK_ACCEPT;
          res[0].last = 1'b1;
        end else if (lo >= SIZE_W'(MAX_SEGMENTS - 1)) begin
          res_cnt = 2'd1;
          res[0].kind = RK_ERROR;
          res[0].err = ERR_SEGMENTS;
          phase_nxt = PH_HALT;
        end else begin
          seg_total_nxt = lo[CNT_W-1:0] + {{(CNT_W-1){1'b0}}, 1'b1};
          next_index_nxt = {{(CNT_W-1){1'b0}}, 1'b1};
          run_offset_nxt = sum_a;
          sum_ovf_nxt = sum_a_full[OFF_W];
          res[0].kind = RK_DESC;
          res[0].size = hi;
          if (lo == '0) begin
            res_cnt = 2'd2;
            res[1] = fin_res;
            words_left_nxt = fin_total;
            phase_nxt = fin_fail ? PH_HALT : ((fin_total == '0) ? PH_IDLE : PH_PAYLOAD);
          end else begin
            res_cnt = 2'd1;
            phase_nxt = PH_TABLE;
          end
        end
      end else begin
        res[0].kind = RK_DESC;
        res[0].index = IDX_W'(next_index_r);
        res[0].offset = run_offset_r;
        res[0].size = lo;
        res[1].kind = RK_DESC;
        res[1].index = IDX_W'(idx1);
        res[1].offset = sum_a;
        res[1].size = hi;
        next_index_nxt = idx2[CNT_W-1:0];
        run_offset_nxt = fin_total;
        sum_ovf_nxt = fin_ovf;
        if (idx2 >= {1'b0, seg_total_r}) begin
          words_left_nxt = fin_total;
          phase_nxt = fin_fail ? PH_HALT : ((fin_total == '0) ? PH_IDLE : PH_PAYLOAD);
          if (do_hi) begin
            res_cnt = 2'd3;
            res[2] = fin_res;
          end else begin
            res_cnt = 2'd2;
            res[1] = fin_res;
          end
        end else begin
          res_cnt = do_hi ? 2'd2 : 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      seg_total_r <= '0;
      next_index_r <= '0;
      run_offset_r <= '0;
      words_left_r <= '0;
      sum_ovf_r <= 1'b0;
      limit_r <= LIMIT_RESET;
      cnt_r <= 2'd0;
    end else begin
      if (cfg_write && (cfg_paddr[CFG_ADDR_W-1] == REG_LIMIT)) begin
        limit_r <= cfg_pwdata[OFF_W-1:0];
      end
      if (in_accept) begin
        phase_r <= phase_nxt;
        seg_total_r <= seg_total_nxt;
        next_index_r <= next_index_nxt;
        run_offset_r <= run_offset_nxt;
        words_left_r <= words_left_nxt;
        sum_ovf_r <= sum_ovf_nxt;
        cnt_r <= res_cnt;
        slot_r[0] <= res[0];
        slot_r[1] <= res[1];
        slot_r[2] <= res[2];
      end else if (out_pop) begin
        cnt_r <= cnt_r - 2'd1;
        slot_r[0] <= slot_r[1];
        slot_r[1] <= slot_r[2];
      end
    end
  end

endmodule

### rtl/core/segdf_chk.sv
// Port-level assertions for the segment table deframer, bound to its top level.
module segdf_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [segdf_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [segdf_pkg::OUT_USER_W-1:0]  out_tuser,
  input logic                              out_tlast
);
  import segdf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("Stalled result item changed.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= RK_END)
    else $error("Result kind out of range.");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == RK_PAYLOAD || out_tuser == RK_ACCEPT)
    else $error("Message end on a result that cannot end a message.");

  a_accept_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == RK_ACCEPT |-> out_tlast == (out_tdata[49:9] == '0))
    else $error("Table accepted end flag disagrees with the message total.");

endmodule

bind segment_table_deframer segdf_chk u_segdf_chk (.*);
